FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_ALWAYS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/m3i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// widths, stage numbers, cofactor table and request types of the 3x3 inverse
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EW        = 32;
  localparam int QW        = 32;
  localparam int NCOF      = 9;
  localparam int PROD_W    = 2 * EW;
  localparam int COF_W     = PROD_W + 1;
  localparam int CMAG_W    = PROD_W;
  localparam int PP_W      = COF_W;
  localparam int HALF_W    = EW + COF_W + 1;
  localparam int DET_W     = HALF_W + 1;
  localparam int DABS_W    = DET_W;
  localparam int DEN_W     = DABS_W + 1;
  localparam int NUM_A     = CMAG_W + 2 * FRAC_BITS + 1;
  localparam int NUM_W     = ((NUM_A > DABS_W) ? NUM_A : DABS_W) + 1;
  localparam int REM_W     = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

  // pipeline stage numbers
  localparam int ST_PROD     = 0;
  localparam int ST_COF      = 1;
  localparam int ST_DPP      = 2;
  localparam int ST_DHALF    = 3;
  localparam int ST_DET      = 4;
  localparam int ST_PREP     = 5;
  localparam int ST_OVF      = 6;
  localparam int ST_DIV0     = 7;
  localparam int ST_LAST_DIV = ST_DIV0 + QW - 1;
  localparam int ST_OUT      = ST_LAST_DIV + 1;
  localparam int NSTG        = ST_OUT + 1;

  typedef logic signed [EW-1:0]     elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [HALF_W-1:0] half_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [DABS_W-1:0]        dabs_t;
  typedef logic [DEN_W-1:0]         den_t;
  typedef logic [REM_W-1:0]         rem_t;
  typedef logic [CMAG_W-1:0]        cmag_t;
  typedef logic [QW-1:0]            quo_t;
  typedef logic [NSTG-1:0]          stage_vec_t;

  // cofactor k = m[a]*m[b] - m[c]*m[d], signs folded into the order
  localparam logic [3:0] COF_IDX [NCOF][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5},
    '{4'd7, 4'd2, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd6, 4'd2},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd6, 4'd1, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  typedef struct packed {
    elem_t a_e0;
    elem_t a_e1;
    elem_t a_e2;
    elem_t a_e3;
    elem_t a_e4;
    elem_t a_e5;
    elem_t a_e6;
    elem_t a_e7;
    elem_t a_e8;
  } mat_t;

  typedef struct packed {
    elem_t inv_e0;
    elem_t inv_e1;
    elem_t inv_e2;
    elem_t inv_e3;
    elem_t inv_e4;
    elem_t inv_e5;
    elem_t inv_e6;
    elem_t inv_e7;
    elem_t inv_e8;
    logic  singular;
    logic  overflowed;
  } res_t;

endpackage

FILE: src/m3i_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_cofactor
// two stages: eighteen element products, then the nine signed cofactors
// ----------------------------------------------------------------------------
module m3i_cofactor (
  input  logic                clk,
  input  m3i_pkg::stage_vec_t en,
  input  m3i_pkg::mat_t       mat,
  output m3i_pkg::elem_t      mcol [3],
  output m3i_pkg::cof_t       cof [m3i_pkg::NCOF]
);
  import m3i_pkg::*;

  elem_t m [NCOF];
  prod_t pa [NCOF];
  prod_t pb [NCOF];
  elem_t mcol_p [3];

  assign m[0] = mat.a_e0;
  assign m[1] = mat.a_e1;
  assign m[2] = mat.a_e2;
  assign m[3] = mat.a_e3;
  assign m[4] = mat.a_e4;
  assign m[5] = mat.a_e5;
  assign m[6] = mat.a_e6;
  assign m[7] = mat.a_e7;
  assign m[8] = mat.a_e8;

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      for (int k = 0; k < NCOF; k++) begin
        pa[k] <= m[COF_IDX[k][0]] * m[COF_IDX[k][1]];
        pb[k] <= m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
      end
      mcol_p[0] <= m[0];
      mcol_p[1] <= m[3];
      mcol_p[2] <= m[6];
    end
    if (en[ST_COF]) begin
      for (int k = 0; k < NCOF; k++) begin
        cof[k] <= cof_t'(pa[k]) - cof_t'(pb[k]);
      end
      for (int i = 0; i < 3; i++) begin
        mcol[i] <= mcol_p[i];
      end
    end
  end

endmodule

FILE: src/m3i_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_det
// determinant along the first column, split products and a two-level sum
// ----------------------------------------------------------------------------
module m3i_det (
  input  logic                clk,
  input  m3i_pkg::stage_vec_t en,
  input  m3i_pkg::elem_t      mcol [3],
  input  m3i_pkg::cof_t       cof [m3i_pkg::NCOF],
  output m3i_pkg::det_t       det,
  output m3i_pkg::cof_t       cof_d [m3i_pkg::NCOF]
);
  import m3i_pkg::*;

  pp_t   plo [3];
  pp_t   phi [3];
  half_t half [3];
  cof_t  cof_a [NCOF];
  cof_t  cof_b [NCOF];

  always_ff @(posedge clk) begin
    if (en[ST_DPP]) begin
      // low word unsigned, high part signed
      for (int i = 0; i < 3; i++) begin
        plo[i] <= mcol[i] * $signed({1'b0, cof[i][EW-1:0]});
        phi[i] <= mcol[i] * $signed(cof[i][COF_W-1:EW]);
      end
      cof_a <= cof;
    end
    if (en[ST_DHALF]) begin
      for (int i = 0; i < 3; i++) begin
        half[i] <= half_t'(plo[i]) + (half_t'(phi[i]) <<< EW);
      end
      cof_b <= cof_a;
    end
    if (en[ST_DET]) begin
      det   <= det_t'(half[0]) + det_t'(half[1]) + det_t'(half[2]);
      cof_d <= cof_b;
    end
  end

endmodule

FILE: src/m3i_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_lane
// one inverse element: rounded restoring division, one quotient bit a stage
// ----------------------------------------------------------------------------
module m3i_lane (
  input  logic                clk,
  input  m3i_pkg::stage_vec_t en,
  input  m3i_pkg::cof_t       cof,
  input  logic                dneg,
  input  m3i_pkg::dabs_t      dabs,
  input  m3i_pkg::den_t       den [m3i_pkg::ST_PREP:m3i_pkg::ST_LAST_DIV-1],
  output m3i_pkg::elem_t      value,
  output logic                sat
);
  import m3i_pkg::*;

  rem_t  rem [ST_PREP:ST_LAST_DIV-1];
  quo_t  quo [ST_OVF:ST_LAST_DIV];
  logic  neg [ST_PREP:ST_LAST_DIV];
  logic  hi  [ST_OVF:ST_LAST_DIV];
  cmag_t cmag;
  rem_t  num;
  quo_t  lim;
  quo_t  mag;
  logic  over;

  // twice the scaled magnitude plus |det| gives round half away from zero
  assign cmag = cof[COF_W-1] ? cmag_t'(-cof) : cmag_t'(cof);
  assign num  = (rem_t'(cmag) << (2 * FRAC_BITS + 1)) + rem_t'(dabs);

  always_ff @(posedge clk) begin
    if (en[ST_PREP]) begin
      rem[ST_PREP] <= num;
      neg[ST_PREP] <= cof[COF_W-1] ^ dneg;
    end
    if (en[ST_OVF]) begin
      rem[ST_OVF] <= rem[ST_PREP];
      neg[ST_OVF] <= neg[ST_PREP];
      quo[ST_OVF] <= '0;
      hi[ST_OVF]  <= rem[ST_PREP] >= (rem_t'(den[ST_PREP]) << QW);
    end
  end

  for (genvar s = ST_DIV0; s <= ST_LAST_DIV; s++) begin : g_div
    localparam int J = ST_LAST_DIV - s;
    rem_t trial;
    logic ge;
    assign trial = rem_t'(den[s-1]) << J;
    assign ge    = rem[s-1] >= trial;
    always_ff @(posedge clk) begin
      if (en[s]) begin
        quo[s]    <= quo[s-1] | (quo_t'(ge) << J);
        neg[s]    <= neg[s-1];
        hi[s]     <= hi[s-1];
      end
    end
    if (s != ST_LAST_DIV) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem[s] <= ge ? rem[s-1] - trial : rem[s-1];
        end
      end
    end
  end

  assign lim   = neg[ST_LAST_DIV] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  assign over  = hi[ST_LAST_DIV] || (quo[ST_LAST_DIV] > lim);
  assign mag   = over ? lim : quo[ST_LAST_DIV];
  assign value = neg[ST_LAST_DIV] ? elem_t'(-mag) : elem_t'(mag);
  assign sat   = over;

endmodule

FILE: src/matrix3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 matrix inverse by the adjugate, signed fixed point in and out
// ----------------------------------------------------------------------------
// One request carries a 3x3 matrix of signed Q16.16 elements; one result
// comes back per request, in order, with the nine inverse elements rounded
// to nearest (halves away from zero), saturated to the 32-bit range with
// overflowed set, or all zero with singular set when the determinant is
// exactly zero. The block takes one matrix every clock unless every stage
// is full and the result is held back. A request passes the cofactor
// products, the determinant, the division setup, a range check and 32
// division stages, one quotient bit each, then the result register. The nine
// elements are divided in nine parallel lanes that share the determinant
// pipeline; the result register merges the lanes and the singular check.
// Stages hold their contents on a stall and bubbles close up, so mat_ready
// stays high while any stage is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix3_inverse (
  input  logic           clk,
  input  logic           rst,
  input  logic           mat_valid,
  output logic           mat_ready,
  input  m3i_pkg::mat_t  mat,
  output logic           res_valid,
  input  logic           res_ready,
  output m3i_pkg::res_t  res
);
  import m3i_pkg::*;

  stage_vec_t       stg_valid;
  logic [NSTG:0]    rdy;
  stage_vec_t       en;
  elem_t            mcol [3];
  cof_t             cof [NCOF];
  cof_t             cof_d [NCOF];
  det_t             det;
  logic             dneg;
  dabs_t            dabs;
  den_t             den [ST_PREP:ST_LAST_DIV-1];
  logic             sing [ST_PREP:ST_LAST_DIV];
  elem_t            val [NCOF];
  logic [NCOF-1:0]  sat;

  // a stage may load when it is empty or its successor moves on
  always_comb begin
    rdy[NSTG] = res_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !stg_valid[k] || rdy[k+1];
    end
  end

  assign en        = rdy[NSTG-1:0];
  assign mat_ready = rdy[0];
  assign res_valid = stg_valid[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      if (en[0]) begin
        stg_valid[0] <= mat_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          stg_valid[k] <= stg_valid[k-1];
        end
      end
    end
  end

  // front end: cofactors and determinant
  m3i_cofactor u_cofactor (
    .clk  (clk),
    .en   (en),
    .mat  (mat),
    .mcol (mcol),
    .cof  (cof)
  );

  m3i_det u_det (
    .clk   (clk),
    .en    (en),
    .mcol  (mcol),
    .cof   (cof),
    .det   (det),
    .cof_d (cof_d)
  );

  // sign and magnitude of the determinant, shared by all lanes
  assign dneg = det[DET_W-1];
  assign dabs = dneg ? dabs_t'(-det) : dabs_t'(det);

  // divisor is twice |det|, carried alongside the lanes
  always_ff @(posedge clk) begin
    if (en[ST_PREP]) begin
      den[ST_PREP]  <= {dabs, 1'b0};
      sing[ST_PREP] <= (det == '0);
    end
    for (int s = ST_PREP + 1; s <= ST_LAST_DIV; s++) begin
      if (en[s]) begin
        sing[s] <= sing[s-1];
      end
    end
    for (int s = ST_PREP + 1; s < ST_LAST_DIV; s++) begin
      if (en[s]) begin
        den[s] <= den[s-1];
      end
    end
  end

  // one division lane per inverse element
  for (genvar k = 0; k < NCOF; k++) begin : g_lane
    m3i_lane u_lane (
      .clk   (clk),
      .en    (en),
      .cof   (cof_d[k]),
      .dneg  (dneg),
      .dabs  (dabs),
      .den   (den),
      .value (val[k]),
      .sat   (sat[k])
    );
  end

  // merge: singular matrix forces zeros, saturation flags are or-ed
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      res.inv_e0     <= sing[ST_LAST_DIV] ? '0 : val[0];
      res.inv_e1     <= sing[ST_LAST_DIV] ? '0 : val[1];
      res.inv_e2     <= sing[ST_LAST_DIV] ? '0 : val[2];
      res.inv_e3     <= sing[ST_LAST_DIV] ? '0 : val[3];
      res.inv_e4     <= sing[ST_LAST_DIV] ? '0 : val[4];
      res.inv_e5     <= sing[ST_LAST_DIV] ? '0 : val[5];
      res.inv_e6     <= sing[ST_LAST_DIV] ? '0 : val[6];
      res.inv_e7     <= sing[ST_LAST_DIV] ? '0 : val[7];
      res.inv_e8     <= sing[ST_LAST_DIV] ? '0 : val[8];
      res.singular   <= sing[ST_LAST_DIV];
      res.overflowed <= !sing[ST_LAST_DIV] && (|sat);
    end
  end

  // requests are refused only when every stage holds an item
  `ASSERT_ALWAYS(a_full_when_blocked, clk, rst, !mat_ready, &stg_valid, "ready low with a bubble")
  // an accepted request always enters the first stage
  `ASSERT_NEXT(a_accept_enters, clk, rst, mat_valid && mat_ready, stg_valid[ST_PROD], "request lost")
  // a singular result carries zeros on the diagonal and no overflow
  `ASSERT_ALWAYS(a_singular_zero, clk, rst, res_valid && res.singular, res.inv_e0 == '0 && res.inv_e4 == '0 && res.inv_e8 == '0 && !res.overflowed, "singular result not cleared")

endmodule
